>>> rtl/sss_pkg.sv
// package for the shamir share splitter: constants, types and gf(2^8) helpers
package sss_pkg;

  localparam int unsigned MaxShares = 16;
  localparam int unsigned IdxW = $clog2(MaxShares);
  localparam int unsigned CntW = 5;
  localparam int unsigned XteaRounds = 32;
  localparam int unsigned RoundW = $clog2(XteaRounds);
  localparam logic [31:0] XteaDelta = 32'h9E37_79B9;
  localparam logic [7:0] GfReduce = 8'h1b;

  localparam logic [1:0] RegKeyLow = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegShareCount = 2'd2;
  localparam logic [1:0] RegThreshold = 2'd3;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StFill  = 7'b0000010,
    StXtea  = 7'b0000100,
    StEvRd  = 7'b0001000,
    StEvAcc = 7'b0010000,
    StOut   = 7'b0100000,
    StBad   = 7'b1000000
  } state_e;

  // multiply by x once in gf(2^8)
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    gf_xtime = a[7] ? ((a << 1) ^ GfReduce) : (a << 1);
  endfunction

  // full gf(2^8) multiply, eight narrow steps
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] t;
    p = '0;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ t;
      t = gf_xtime(t);
    end
    gf_mul = p;
  endfunction

endpackage

>>> rtl/sss_ram.sv
// generic single port ram with registered read
module sss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/shamir_share_splitter_gf256.sv
// Shamir share splitter over gf(2^8): one secret byte in, share_count share bytes out
// (one zeroed result flagged params_bad for bad parameters). Sequence: the item is accepted,
// the threshold-1 coefficients are filled from the generator (an xtea refill, one load and
// 32 rounds, every 8 random bytes), then per share horner steps read the coefficient ram
// one entry at a time and the share is output. One item at a time: a new secret byte is
// accepted only in idle, after the last share or the bad-parameter result has been taken.
// Reset: asynchronous active low; registers take their reset values, generator empty.
module shamir_share_splitter_gf256 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  secret_byte_i,
  input  logic        start_of_secret_i,
  input  logic        end_of_secret_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  share_x_o,
  output logic [7:0]  share_byte_o,
  output logic        last_of_run_o,
  output logic        secret_done_o,
  output logic        params_bad_o
);

  localparam int unsigned IdxW = sss_pkg::IdxW;
  localparam int unsigned CntW = sss_pkg::CntW;

  sss_pkg::state_e state_q, state_d;

  logic [63:0] key_low_q, key_high_q;
  logic [CntW-1:0] share_count_q, threshold_q;
  logic [63:0] ctr_q, blk_q;
  logic [3:0]  pos_q;
  logic [31:0] lo_q, hi_q, acc_q;
  logic [sss_pkg::RoundW-1:0] rnd_q;
  logic [CntW-1:0] k_q, s_q;
  logic [7:0] hacc_q;
  logic done_q;

  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;

  // apb port
  logic [1:0] reg_idx;
  logic cfg_wr;
  assign pready = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr = psel & penable & pwrite & (paddr[2:0] == 3'd0);

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (reg_idx)
        sss_pkg::RegKeyLow:     prdata = key_low_q;
        sss_pkg::RegKeyHigh:    prdata = key_high_q;
        sss_pkg::RegShareCount: prdata = {59'd0, share_count_q};
        sss_pkg::RegThreshold:  prdata = {59'd0, threshold_q};
        default:                prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q     <= '0;
      key_high_q    <= '0;
      share_count_q <= CntW'(1);
      threshold_q   <= CntW'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sss_pkg::RegKeyLow:     key_low_q <= pwdata;
        sss_pkg::RegKeyHigh:    key_high_q <= pwdata;
        sss_pkg::RegShareCount: share_count_q <= pwdata[CntW-1:0];
        sss_pkg::RegThreshold:  threshold_q <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // xtea round helpers
  function automatic logic [31:0] key_word(input logic [1:0] i, input logic [63:0] kl,
                                           input logic [63:0] kh);
    logic [63:0] k;
    k = i[1] ? kh : kl;
    key_word = i[0] ? k[63:32] : k[31:0];
  endfunction

  logic [31:0] lo_n, acc_n, hi_n;
  always_comb begin
    lo_n  = lo_q + ((((hi_q << 4) ^ (hi_q >> 5)) + hi_q) ^
            (acc_q + key_word(acc_q[1:0], key_low_q, key_high_q)));
    acc_n = acc_q + sss_pkg::XteaDelta;
    hi_n  = hi_q + ((((lo_n << 4) ^ (lo_n >> 5)) + lo_n) ^
            (acc_n + key_word(acc_n[12:11], key_low_q, key_high_q)));
  end

  logic bad;
  assign bad = (threshold_q == '0) || (threshold_q > share_count_q) ||
               (share_count_q > CntW'(sss_pkg::MaxShares));

  logic in_acc, out_acc;
  assign in_ready_o = (state_q == sss_pkg::StIdle);
  assign in_acc = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == sss_pkg::StOut) || (state_q == sss_pkg::StBad);
  assign out_acc = out_valid_o & out_ready_i;

  logic [7:0] rbyte;
  assign rbyte = blk_q[{pos_q[2:0], 3'b000} +: 8];

  logic [CntW-1:0] x_val;
  logic last_share;
  assign x_val = s_q + CntW'(1);
  assign last_share = (x_val == share_count_q);

  // coefficient ram access
  always_comb begin
    ram_we = 1'b0;
    ram_addr = k_q[IdxW-1:0];
    ram_wdata = rbyte;
    if (in_acc) begin
      ram_we = ~bad;
      ram_addr = '0;
      ram_wdata = secret_byte_i;
    end else if (state_q == sss_pkg::StFill && pos_q[3] == 1'b0) begin
      ram_we = 1'b1;
    end
  end

  sss_ram #(.Width(8), .Depth(sss_pkg::MaxShares)) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sss_pkg::StIdle:
        if (in_acc) begin
          if (bad) state_d = sss_pkg::StBad;
          else if (threshold_q == CntW'(1)) state_d = sss_pkg::StEvRd;
          else state_d = sss_pkg::StFill;
        end
      sss_pkg::StFill:
        if (pos_q[3]) state_d = sss_pkg::StXtea;
        else if (k_q == threshold_q - CntW'(1)) state_d = sss_pkg::StEvRd;
      sss_pkg::StXtea:
        if (rnd_q == '1) state_d = sss_pkg::StFill;
      sss_pkg::StEvRd: state_d = sss_pkg::StEvAcc;
      sss_pkg::StEvAcc:
        if (k_q == '0) state_d = sss_pkg::StOut;
        else state_d = sss_pkg::StEvRd;
      sss_pkg::StOut:
        if (out_acc) state_d = last_share ? sss_pkg::StIdle : sss_pkg::StEvRd;
      sss_pkg::StBad:
        if (out_acc) state_d = sss_pkg::StIdle;
      default: state_d = sss_pkg::StIdle;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sss_pkg::StIdle;
      ctr_q   <= '0;
      blk_q   <= '0;
      pos_q   <= 4'd8;
      lo_q    <= '0;
      hi_q    <= '0;
      acc_q   <= '0;
      rnd_q   <= '0;
      k_q     <= '0;
      s_q     <= '0;
      hacc_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        sss_pkg::StIdle:
          if (in_acc) begin
            done_q <= end_of_secret_i;
            s_q <= '0;
            if (start_of_secret_i) begin
              ctr_q <= '0;
              pos_q <= 4'd8;
            end
            k_q <= (bad || threshold_q == CntW'(1)) ? threshold_q - CntW'(1) : CntW'(1);
          end
        sss_pkg::StFill:
          if (pos_q[3]) begin
            lo_q  <= ctr_q[31:0];
            hi_q  <= ctr_q[63:32];
            acc_q <= '0;
            rnd_q <= '0;
          end else begin
            pos_q <= pos_q + 4'd1;
            if (k_q != threshold_q - CntW'(1)) k_q <= k_q + CntW'(1);
          end
        sss_pkg::StXtea: begin
          lo_q  <= lo_n;
          hi_q  <= hi_n;
          acc_q <= acc_n;
          rnd_q <= rnd_q + sss_pkg::RoundW'(1);
          if (rnd_q == '1) begin
            blk_q <= {hi_n, lo_n};
            ctr_q <= ctr_q + 64'd1;
            pos_q <= '0;
          end
        end
        sss_pkg::StEvRd: ;
        sss_pkg::StEvAcc: begin
          // top coefficient seeds the accumulator, then horner steps
          if (k_q == threshold_q - CntW'(1)) hacc_q <= ram_rdata;
          else hacc_q <= sss_pkg::gf_mul(hacc_q, {3'b000, x_val}) ^ ram_rdata;
          if (k_q != '0) k_q <= k_q - CntW'(1);
        end
        sss_pkg::StOut:
          if (out_acc) begin
            s_q <= s_q + CntW'(1);
            k_q <= threshold_q - CntW'(1);
          end
        default: ;
      endcase
    end
  end

  // result fields
  assign share_x_o     = (state_q == sss_pkg::StBad) ? '0 : x_val;
  assign share_byte_o  = (state_q == sss_pkg::StBad) ? 8'd0 : hacc_q;
  assign last_of_run_o = (state_q == sss_pkg::StBad) | last_share;
  assign secret_done_o = ((state_q == sss_pkg::StBad) | last_share) & done_q;
  assign params_bad_o  = (state_q == sss_pkg::StBad);

endmodule

>>> tb/tb_top.sv
// testbench for the shamir share splitter: directed table, random items, share predictor
`timescale 1ns / 100ps

module tb_top;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  secret_byte_i;
  logic        start_of_secret_i;
  logic        end_of_secret_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  share_x_o;
  logic [7:0]  share_byte_o;
  logic        last_of_run_o;
  logic        secret_done_o;
  logic        params_bad_o;

  typedef struct packed {
    logic [4:0] x;
    logic [7:0] val;
    logic       last;
    logic       done;
    logic       bad;
  } share_t;

  typedef struct packed {
    logic [7:0] secret;
    logic       sos;
    logic       eos;
    logic       fixed;
    share_t     want;
  } row_t;

  // predictor copy of config and generator state
  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  nshares_q, thresh_q;
  logic [63:0] ctr_q, blk_q;
  int unsigned pos_q;

  share_t share_q[$];
  int     mismatches;
  longint cycles;
  bit     hold_long;

  shamir_share_splitter_gf256 i_dut (.*);

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2000000) begin
      $display("[shamir_share_splitter_gf256] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] key_word(input logic [1:0] i);
    logic [63:0] k;
    k = i[1] ? key_hi_q : key_lo_q;
    return i[0] ? k[63:32] : k[31:0];
  endfunction

  function automatic logic [63:0] xtea_enc(input logic [63:0] b);
    logic [31:0] lo, hi, acc;
    lo = b[31:0];
    hi = b[63:32];
    acc = '0;
    for (int r = 0; r < 32; r++) begin
      lo += (((hi << 4) ^ (hi >> 5)) + hi) ^ (acc + key_word(acc[1:0]));
      acc += 32'h9E3779B9;
      hi += (((lo << 4) ^ (lo >> 5)) + lo) ^ (acc + key_word(acc[12:11]));
    end
    return {hi, lo};
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return p;
  endfunction

  function automatic logic [7:0] draw_byte();
    logic [7:0] r;
    if (pos_q >= 8) begin
      blk_q = xtea_enc(ctr_q);
      ctr_q += 1;
      pos_q = 0;
    end
    r = blk_q[8*pos_q +: 8];
    pos_q++;
    return r;
  endfunction

  // expected shares for one accepted item
  task automatic predict_shares(input logic [7:0] sec, input logic sos, input logic eos);
    logic [7:0] coef[16];
    logic [7:0] acc;
    share_t     s;
    if (sos) begin
      ctr_q = '0;
      pos_q = 8;
    end
    if (thresh_q == 0 || thresh_q > nshares_q || nshares_q > 16) begin
      s = '{x: 5'd0, val: 8'd0, last: 1'b1, done: eos, bad: 1'b1};
      share_q.push_back(s);
    end else begin
      coef[0] = sec;
      for (int i = 1; i < thresh_q; i++) coef[i] = draw_byte();
      for (int x = 1; x <= nshares_q; x++) begin
        acc = coef[thresh_q - 1];
        for (int k = thresh_q - 2; k >= 0; k--) acc = gf_times(acc, 8'(x)) ^ coef[k];
        s = '{x: 5'(x), val: acc, last: (x == nshares_q), done: (x == nshares_q) && eos,
              bad: 1'b0};
        share_q.push_back(s);
      end
    end
  endtask

  // apb write, setup then access
  task automatic reg_write(input logic [1:0] idx, input logic [63:0] v);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 5'(idx) << 3; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      sss_pkg::RegKeyLow:     key_lo_q = v;
      sss_pkg::RegKeyHigh:    key_hi_q = v;
      sss_pkg::RegShareCount: nshares_q = v[4:0];
      default:                thresh_q = v[4:0];
    endcase
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  // offer one item and wait for acceptance
  task automatic send_item(input logic [7:0] sec, input logic sos, input logic eos);
    idle_gap();
    @(negedge clk_i);
    in_valid_i = 1'b1;
    secret_byte_i = sec;
    start_of_secret_i = sos;
    end_of_secret_i = eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_shares(sec, sos, eos);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (share_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  // output checker
  always @(posedge clk_i) begin
    share_t got, exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{x: share_x_o, val: share_byte_o, last: last_of_run_o, done: secret_done_o,
              bad: params_bad_o};
      if (share_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected share %p", got);
      end else begin
        exp_s = share_q.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) $display("share mismatch exp %p got %p", exp_s, got);
        end
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_long) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    row_t  dir[$];
    row_t  r;
    int    sets;
    int    sc, th;
    mismatches = 0;
    cycles = 0;
    hold_long = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; secret_byte_i = '0; start_of_secret_i = 1'b0; end_of_secret_i = 1'b0;
    key_lo_q = '0; key_hi_q = '0; nshares_q = 5'd1; thresh_q = 5'd1;
    ctr_q = '0; blk_q = '0; pos_q = 8;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset: one share equal to the secret
    dir.push_back('{8'h00, 1'b1, 1'b0, 1'b1, '{5'd1, 8'h00, 1'b1, 1'b0, 1'b0}});
    dir.push_back('{8'hFF, 1'b0, 1'b1, 1'b1, '{5'd1, 8'hFF, 1'b1, 1'b1, 1'b0}});
    dir.push_back('{8'hA5, 1'b0, 1'b0, 1'b0, '0});
    foreach (dir[i]) begin
      r = dir[i];
      send_item(r.secret, r.sos, r.eos);
      if (r.fixed && share_q[$] !== r.want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d exp %p predicted %p", i, r.want, share_q[$]);
      end
    end
    drain();

    // bad parameters: threshold zero, threshold above count, count above the maximum
    reg_write(sss_pkg::RegThreshold, 64'd0);
    send_item(8'h12, 1'b1, 1'b1);
    drain();
    reg_write(sss_pkg::RegShareCount, 64'd3);
    reg_write(sss_pkg::RegThreshold, 64'd4);
    send_item(8'h34, 1'b0, 1'b0);
    drain();
    reg_write(sss_pkg::RegShareCount, 64'd31);
    reg_write(sss_pkg::RegThreshold, 64'd17);
    send_item(8'h56, 1'b1, 1'b1);
    drain();

    // extremes of keys and sizes
    reg_write(sss_pkg::RegKeyLow, '1);
    reg_write(sss_pkg::RegKeyHigh, '1);
    reg_write(sss_pkg::RegShareCount, 64'd16);
    reg_write(sss_pkg::RegThreshold, 64'd16);
    for (int i = 0; i < 4; i++) send_item(8'(i * 85), i == 0, i == 3);
    drain();
    reg_write(sss_pkg::RegKeyLow, 64'h0123456789ABCDEF);
    reg_write(sss_pkg::RegKeyHigh, 64'hFEDCBA9876543210);
    reg_write(sss_pkg::RegShareCount, 64'd16);
    reg_write(sss_pkg::RegThreshold, 64'd1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b0, 1'b1);
    drain();
    reg_write(sss_pkg::RegShareCount, 64'd2);
    reg_write(sss_pkg::RegThreshold, 64'd2);
    for (int i = 0; i < 10; i++) send_item(8'($urandom), 1'b0, i == 9);
    drain();

    // long receiver hold-off while the sender keeps going
    reg_write(sss_pkg::RegShareCount, 64'd4);
    reg_write(sss_pkg::RegThreshold, 64'd3);
    fork
      begin
        hold_long = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_long = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_item(8'($urandom), i == 0, i == 5);
    join
    drain();

    // random secrets in sets, each set under its own settings
    sets = 0;
    while (sets < 13) begin
      reg_write(sss_pkg::RegKeyLow, {$urandom, $urandom});
      reg_write(sss_pkg::RegKeyHigh, {$urandom, $urandom});
      sc = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      th = $urandom_range(1, sc);
      if ($urandom_range(0, 9) == 0) th = $urandom_range(0, 20);
      reg_write(sss_pkg::RegShareCount, 64'(sc));
      reg_write(sss_pkg::RegThreshold, 64'(th));
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(8'($urandom), 1'($urandom), 1'($urandom));
        else
          send_item(8'($urandom), i == 0, i == 7);
      end
      drain();
      sets++;
    end

    if (mismatches == 0 && share_q.size() == 0) begin
      $display("[shamir_share_splitter_gf256] OK");
    end else begin
      $display("[shamir_share_splitter_gf256] ERROR");
    end
    $finish;
  end

endmodule
